### sv/tpo_pkg.sv
// Constants, register codes and the glyph ROM shared by the text panel overlay.
`default_nettype none

package tpo_pkg;

    // Geometry of the text store and of one glyph cell.
    localparam int SCALE      = 2;
    localparam int LINES      = 4;
    localparam int LINE_CHARS = 32;

    localparam int CELL_W  = 6 * SCALE;
    localparam int GLYPH_W = 5 * SCALE;
    localparam int GLYPH_H = 7 * SCALE;
    localparam int LINE_H  = 7 * SCALE + 4;

    // Field widths of the stream items and of the registers.
    localparam int COORD_W     = 8;
    localparam int COLOR_W     = 16;
    localparam int CODE_W      = 8;
    localparam int TEXT_LINE_W = 2;
    localparam int TEXT_COL_W  = 5;
    localparam int MAX_CHARS_W = 6;
    localparam int LIMIT_W     = MAX_CHARS_W + 1;

    localparam int IN_FIELDS_W = TEXT_LINE_W + TEXT_COL_W + CODE_W + 2 * COORD_W + COLOR_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Text store addressing.
    localparam int ADDR_W     = $clog2(LINES * LINE_CHARS);
    localparam int LINE_IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int COL_IDX_W  = $clog2(LINE_CHARS);
    localparam int CX_W       = $clog2(CELL_W);
    localparam int RY_W       = $clog2(LINE_H);

    // Division by a constant: multiply by a rounded-up reciprocal and keep the high bits.
    // Exact for every dividend below 256 with these divisors.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] CELL_RECIP  =
        RECIP_W'(((1 << RECIP_SHIFT) + CELL_W - 1) / CELL_W);
    localparam logic [RECIP_W-1:0] LINE_RECIP  =
        RECIP_W'(((1 << RECIP_SHIFT) + LINE_H - 1) / LINE_H);
    localparam logic [RECIP_W-1:0] SCALE_RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + SCALE - 1) / SCALE);
    localparam int SUB_IN_W = 6;
    localparam int GPOS_W   = 3;

    // Item kinds carried in tuser.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PANEL_X   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PANEL_Y   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CHARS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR  = 3'd4;

    // Register reset values.
    localparam logic [COORD_W-1:0]     PANEL_X_RST   = 8'd4;
    localparam logic [COORD_W-1:0]     PANEL_Y_RST   = 8'd4;
    localparam logic [MAX_CHARS_W-1:0] MAX_CHARS_RST = 6'd19;
    localparam logic [COLOR_W-1:0]     FG_COLOR_RST  = 16'hFFFF;
    localparam logic [COLOR_W-1:0]     BG_COLOR_RST  = 16'h0000;

    // Printable character range of the font.
    localparam logic [CODE_W-1:0] CHAR_FIRST = 8'd32;
    localparam logic [CODE_W-1:0] CHAR_LAST  = 8'd126;

    localparam int GLYPH_COUNT = 95;
    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
    localparam int GLYPH_COLS  = 5;

    // One glyph: five column bytes, column 0 in the low byte, bit 0 is the top row.
    typedef logic [8*GLYPH_COLS-1:0] glyph_t;

    localparam glyph_t GLYPH_ROM [GLYPH_COUNT] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
        40'h0041221C00, 40'h001C224100, 40'h14083E0814, 40'h08083E0808,
        40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
        40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
        40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
        40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
        40'h0041221408, 40'h1414141414, 40'h0814224100, 40'h0609510102,
        40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
        40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h7A4949413E,
        40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
        40'h404040407F, 40'h7F020C027F, 40'h7F1008047F, 40'h3E4141413E,
        40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h4345495161, 40'h0041417F00,
        40'h2010080402, 40'h007F414100, 40'h0402010204, 40'h4040404040,
        40'h0004020100, 40'h7854545420, 40'h384444487F, 40'h2044444438,
        40'h7F48444438, 40'h1854545438, 40'h0201097E08, 40'h3E5252520C,
        40'h780404087F, 40'h00407D4400, 40'h003D444020, 40'h004428107F,
        40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
        40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448,
        40'h2040443F04, 40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h3C5050500C, 40'h444C546444, 40'h0041360800,
        40'h00007F0000, 40'h0008364100, 40'h0810080810
    };

endpackage

`default_nettype wire

### sv/text_panel_pixel_overlay.sv
// Each item passes three register stages (first, second, output) before m_tvalid shows its result.
// Throughput: one transaction per cycle unless m_tready stalls; the single-port text RAM is read or
// written once per item, in the second stage, so writes and later queries see each other in order.
// Reset: configuration returns to its defaults, the per-line nonzero masks and the panel-shown
// flag clear, and the pipeline empties; the text RAM is not cleared, and no clearing pass runs.
`default_nettype none

module text_panel_pixel_overlay (
    input  logic                            clk,
    input  logic                            rst_n,
    // Slave side.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata from bit 0: text_line, text_column, char_code, pixel_x, pixel_y, under_color, pad.
    input  logic [tpo_pkg::IN_DATA_W-1:0]   s_tdata,
    // tuser: kind.
    input  logic [0:0]                      s_tuser,
    // Master side.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: pixel_color.
    output logic [tpo_pkg::COLOR_W-1:0]     m_tdata,
    // tuser: covered.
    output logic [0:0]                      m_tuser,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [tpo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tpo_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tpo_pkg::*;

    localparam int PROD_W     = COORD_W + RECIP_W;
    localparam int SUB_PROD_W = SUB_IN_W + RECIP_W;

    // Configuration registers.
    logic [COORD_W-1:0]     panel_x_reg;
    logic [COORD_W-1:0]     panel_y_reg;
    logic [MAX_CHARS_W-1:0] max_chars_reg;
    logic [COLOR_W-1:0]     fg_color_reg;
    logic [COLOR_W-1:0]     bg_color_reg;

    // Block state.
    logic [CODE_W-1:0]     text_mem [LINES*LINE_CHARS];
    logic [LINE_CHARS-1:0] mask_reg [LINES];
    logic                  shown_reg;

    // Stage enables.
    logic en_out;
    logic en2;
    logic en1;
    logic accept;
    logic adv2;
    logic adv3;

    // Input stage signals.
    logic               in_kind;
    logic [TEXT_LINE_W-1:0] in_line;
    logic [TEXT_COL_W-1:0]  in_col;
    logic [CODE_W-1:0]  in_code;
    logic [COORD_W-1:0] in_px;
    logic [COORD_W-1:0] in_py;
    logic [COLOR_W-1:0] in_under;
    logic [COORD_W-1:0] in_dx;
    logic [COORD_W-1:0] in_dy;
    logic               in_before;
    logic [PROD_W-1:0]  cell_prod;
    logic [PROD_W-1:0]  line_prod;

    // First pipeline stage.
    logic                   p1_valid_reg;
    logic                   p1_kind_reg;
    logic [TEXT_LINE_W-1:0] p1_line_reg;
    logic [TEXT_COL_W-1:0]  p1_col_reg;
    logic [CODE_W-1:0]      p1_code_reg;
    logic [COLOR_W-1:0]     p1_under_reg;
    logic [COORD_W-1:0]     p1_dx_reg;
    logic [COORD_W-1:0]     p1_dy_reg;
    logic                   p1_before_reg;
    logic [COORD_W-1:0]     p1_cell_reg;
    logic [COORD_W-1:0]     p1_lineq_reg;

    // Second stage signals.
    logic [COORD_W-1:0]    cell_base;
    logic [COORD_W-1:0]    line_base;
    logic [COORD_W-1:0]    s2_cx;
    logic [COORD_W-1:0]    s2_ry;
    logic [LIMIT_W-1:0]    s2_limit;
    logic                  s2_line_ok;
    logic [LINE_IDX_W-1:0] s2_line_idx;
    logic [LINE_CHARS-1:0] s2_mask_line;
    logic [LINE_CHARS-1:0] s2_need;
    logic                  s2_prefix_ok;
    logic                  s2_hit;
    logic                  wr_ok;
    logic [ADDR_W-1:0]     mem_addr;

    logic               p2_valid_reg;
    logic               p2_hit_reg;
    logic [CX_W-1:0]    p2_cx_reg;
    logic [RY_W-1:0]    p2_ry_reg;
    logic [COLOR_W-1:0] p2_under_reg;
    logic [CODE_W-1:0]  rd_data_reg;

    // Third stage signals.
    logic                   s3_printable;
    logic [GLYPH_IDX_W-1:0] s3_gidx;
    logic [SUB_PROD_W-1:0]  col_prod;
    logic [SUB_PROD_W-1:0]  row_prod;
    logic [GPOS_W-1:0]      s3_col;
    logic [GPOS_W-1:0]      s3_row;
    logic [GPOS_W-1:0]      s3_col_sel;
    logic [7:0]             s3_bits;
    logic [COLOR_W-1:0]     s3_color;

    // Output register.
    logic               out_valid_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_covered_reg;

    // Each stage moves when the one after it is empty or moving.
    assign en_out   = !out_valid_reg || m_tready;
    assign en2      = !p2_valid_reg || en_out;
    assign en1      = !p1_valid_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && s_tready;
    assign adv2     = p1_valid_reg && en2;
    assign adv3     = p2_valid_reg && en_out;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_x_reg   <= PANEL_X_RST;
            panel_y_reg   <= PANEL_Y_RST;
            max_chars_reg <= MAX_CHARS_RST;
            fg_color_reg  <= FG_COLOR_RST;
            bg_color_reg  <= BG_COLOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PANEL_X:   panel_x_reg   <= cfg_data[COORD_W-1:0];
                REG_PANEL_Y:   panel_y_reg   <= cfg_data[COORD_W-1:0];
                REG_MAX_CHARS: max_chars_reg <= cfg_data[MAX_CHARS_W-1:0];
                REG_FG_COLOR:  fg_color_reg  <= cfg_data[COLOR_W-1:0];
                REG_BG_COLOR:  bg_color_reg  <= cfg_data[COLOR_W-1:0];
                default:       ;
            endcase
        end
    end

    // Unpack the transaction and divide the panel offsets into cell and line numbers.
    always_comb
    begin
        in_kind   = s_tuser[0];
        in_line   = s_tdata[1:0];
        in_col    = s_tdata[6:2];
        in_code   = s_tdata[14:7];
        in_px     = s_tdata[22:15];
        in_py     = s_tdata[30:23];
        in_under  = s_tdata[46:31];
        in_dx     = in_px - panel_x_reg;
        in_dy     = in_py - panel_y_reg;
        in_before = (in_px < panel_x_reg) || (in_py < panel_y_reg);
        cell_prod = PROD_W'(in_dx) * PROD_W'(CELL_RECIP);
        line_prod = PROD_W'(in_dy) * PROD_W'(LINE_RECIP);
    end

    // First stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (en1)
        begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_kind_reg   <= in_kind;
            p1_line_reg   <= in_line;
            p1_col_reg    <= in_col;
            p1_code_reg   <= in_code;
            p1_under_reg  <= in_under;
            p1_dx_reg     <= in_dx;
            p1_dy_reg     <= in_dy;
            p1_before_reg <= in_before;
            p1_cell_reg   <= cell_prod[RECIP_SHIFT +: COORD_W];
            p1_lineq_reg  <= line_prod[RECIP_SHIFT +: COORD_W];
        end
    end

    // Position inside the cell, visibility checks and the text RAM address.
    always_comb
    begin
        cell_base    = p1_cell_reg * COORD_W'(CELL_W);
        line_base    = p1_lineq_reg * COORD_W'(LINE_H);
        s2_cx        = p1_dx_reg - cell_base;
        s2_ry        = p1_dy_reg - line_base;
        s2_limit     = (LIMIT_W'(max_chars_reg) < LIMIT_W'(LINE_CHARS)) ?
                       LIMIT_W'(max_chars_reg) : LIMIT_W'(LINE_CHARS);
        s2_line_ok   = p1_lineq_reg < COORD_W'(LINES);
        s2_line_idx  = p1_lineq_reg[LINE_IDX_W-1:0];
        s2_mask_line = s2_line_ok ? mask_reg[s2_line_idx] : '0;
        for (int k = 0; k < LINE_CHARS; k++)
        begin
            s2_need[k] = COORD_W'(k) <= p1_cell_reg;
        end
        // Every column up to and including this one must hold a nonzero byte.
        s2_prefix_ok = &(s2_mask_line | ~s2_need);
        s2_hit       = (p1_kind_reg == KIND_QUERY) && shown_reg && !p1_before_reg &&
                       (s2_cx < COORD_W'(GLYPH_W)) && (s2_ry < COORD_W'(GLYPH_H)) &&
                       s2_line_ok && (p1_cell_reg < COORD_W'(s2_limit)) && s2_prefix_ok;
        wr_ok        = (p1_kind_reg == KIND_WRITE) && (32'(p1_line_reg) < LINES) &&
                       (32'(p1_col_reg) < LINE_CHARS);
        if (p1_kind_reg == KIND_WRITE)
        begin
            mem_addr = ADDR_W'(32'(p1_line_reg) * LINE_CHARS + 32'(p1_col_reg));
        end
        else
        begin
            mem_addr = ADDR_W'(32'(p1_lineq_reg) * LINE_CHARS + 32'(p1_cell_reg));
        end
    end

    // Text RAM: one access per item, write for a character, read for a query.
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            if (wr_ok)
            begin
                text_mem[mem_addr] <= p1_code_reg;
            end
            rd_data_reg <= text_mem[mem_addr];
        end
    end

    // Nonzero masks and the panel-shown flag follow every write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LINES; l++)
            begin
                mask_reg[l] <= '0;
            end
            shown_reg <= 1'b0;
        end
        else if (adv2 && (p1_kind_reg == KIND_WRITE))
        begin
            shown_reg <= 1'b1;
            if (wr_ok)
            begin
                mask_reg[LINE_IDX_W'(p1_line_reg)][COL_IDX_W'(p1_col_reg)] <=
                    (p1_code_reg != '0);
            end
        end
    end

    // Second stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            p2_hit_reg   <= s2_hit;
            p2_cx_reg    <= s2_cx[CX_W-1:0];
            p2_ry_reg    <= s2_ry[RY_W-1:0];
            p2_under_reg <= p1_under_reg;
        end
    end

    // Glyph lookup and color choice.
    always_comb
    begin
        s3_printable = (rd_data_reg >= CHAR_FIRST) && (rd_data_reg <= CHAR_LAST);
        s3_gidx      = s3_printable ? GLYPH_IDX_W'(rd_data_reg - CHAR_FIRST) : '0;
        col_prod     = SUB_PROD_W'(p2_cx_reg) * SUB_PROD_W'(SCALE_RECIP);
        row_prod     = SUB_PROD_W'(p2_ry_reg) * SUB_PROD_W'(SCALE_RECIP);
        s3_col       = col_prod[RECIP_SHIFT +: GPOS_W];
        s3_row       = row_prod[RECIP_SHIFT +: GPOS_W];
        s3_col_sel   = (s3_col < GPOS_W'(GLYPH_COLS)) ? s3_col : '0;
        s3_bits      = GLYPH_ROM[s3_gidx][{s3_col_sel, 3'b000} +: 8];
        s3_color     = s3_bits[s3_row] ? fg_color_reg : bg_color_reg;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            out_color_reg   <= p2_hit_reg ? s3_color : p2_under_reg;
            out_covered_reg <= p2_hit_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_color_reg;
    assign m_tuser[0] = out_covered_reg;

    // A covered pixel needs the panel to have been shown by an earlier write.
    a_hit_needs_shown: assert property (@(posedge clk) disable iff (!rst_n)
        adv2 && s2_hit |-> shown_reg)
        else $error("covered pixel while the panel is hidden");

    // A covered pixel reads a column whose stored byte is nonzero.
    a_hit_reads_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        adv2 && s2_hit |-> s2_mask_line[COL_IDX_W'(p1_cell_reg)])
        else $error("covered pixel reads an empty column");

    // The slave side is held back only by a stalled, full output.
    a_backpressure_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready && p1_valid_reg && p2_valid_reg))
        else $error("slave side stalled without a full pipeline");

    // A covered result carries one of the two glyph colors.
    a_covered_color: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == fg_color_reg) || (m_tdata == bg_color_reg))
        else $error("covered pixel with a color that is neither foreground nor background");

endmodule

`default_nettype wire
